// ===== rtl/core/sdhe_pkg.sv =====
// Shared types and constants for the switch debounce and hold event block.
package sdhe_pkg;

    localparam int THR_W      = 8;
    localparam int HOLD_W     = 10;
    localparam int CFG_DATA_W = 10;
    localparam int ST_W       = 2;
    localparam int EV_W       = 3;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 8'h7F;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 10'd100;
    localparam logic [HOLD_W-1:0] HOLD_COUNT_MAX   = 10'h3FF;

    typedef enum logic {
        REG_THRESHOLD  = 1'b0,
        REG_HOLD_TICKS = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_POLL = 1'b1
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OPEN   = 2'd0,
        ST_CLOSED = 2'd1,
        ST_HELD   = 2'd2
    } t_sw_state;

    typedef enum logic [EV_W-1:0] {
        EV_NONE       = 3'd0,
        EV_RELEASE    = 3'd1,
        EV_HOLD_ENTER = 3'd2,
        EV_HOLDING    = 3'd3,
        EV_HOLD_EXIT  = 3'd4
    } t_event;

    typedef struct packed {
        t_op  op;
        logic pin_low;
    } t_item;

    typedef struct packed {
        t_sw_state state;
        t_event    event_code;
    } t_result;

endpackage

// ===== rtl/core/sdhe_cfg.sv =====
// Configuration registers for the debounce threshold and the hold limit.
module sdhe_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  sdhe_pkg::t_cfg_reg               i_cfg_index,
    input  logic [sdhe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [sdhe_pkg::THR_W-1:0]       o_threshold,
    output logic [sdhe_pkg::HOLD_W-1:0]      o_hold_ticks
);
    import sdhe_pkg::*;

    logic [THR_W-1:0]  r_threshold;
    logic [HOLD_W-1:0] r_hold_ticks;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_hold_ticks <= HOLD_TICKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                REG_HOLD_TICKS: r_hold_ticks <= i_cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    assign o_threshold  = r_threshold;
    assign o_hold_ticks = r_hold_ticks;

endmodule

// ===== rtl/core/sdhe_qual.sv =====
// Debounce history, hold counter, poll tracking and the per-word result logic.
module sdhe_qual #(
    parameter int HISTORY_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  sdhe_pkg::t_item              i_item,
    input  logic [sdhe_pkg::THR_W-1:0]   i_threshold,
    input  logic [sdhe_pkg::HOLD_W-1:0]  i_hold_ticks,
    output sdhe_pkg::t_result            o_result
);
    import sdhe_pkg::*;

    localparam int CMP_W = (HISTORY_BITS > THR_W) ? HISTORY_BITS : THR_W;

    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic                    r_closed, n_closed;
    logic                    r_held, n_held;
    logic [HOLD_W-1:0]       r_count, n_count;
    t_sw_state               r_last, n_last;

    t_sw_state         cur_state;
    t_sw_state         tick_state;
    logic [HOLD_W-1:0] count_inc;
    logic              closed_new;
    logic              held_new;
    logic [HOLD_W-1:0] count_new;
    logic [HISTORY_BITS-1:0] hist_new;
    t_event            poll_event;

    always_comb begin
        if (!r_closed) begin
            cur_state = ST_OPEN;
        end else if (r_held) begin
            cur_state = ST_HELD;
        end else begin
            cur_state = ST_CLOSED;
        end
    end

    always_comb begin
        hist_new = {r_hist[HISTORY_BITS-2:0], i_item.pin_low};

        if (CMP_W'(hist_new) >= CMP_W'(i_threshold)) begin
            closed_new = 1'b1;
        end else if (hist_new == '0) begin
            closed_new = 1'b0;
        end else begin
            closed_new = r_closed;
        end

        if (cur_state == ST_CLOSED && r_count != HOLD_COUNT_MAX) begin
            count_inc = r_count + HOLD_W'(1);
        end else begin
            count_inc = r_count;
        end

        if (closed_new && count_inc >= i_hold_ticks) begin
            count_new = i_hold_ticks;
            held_new  = 1'b1;
        end else if (!closed_new) begin
            count_new = '0;
            held_new  = 1'b0;
        end else begin
            count_new = count_inc;
            held_new  = r_held;
        end

        if (!closed_new) begin
            tick_state = ST_OPEN;
        end else if (held_new) begin
            tick_state = ST_HELD;
        end else begin
            tick_state = ST_CLOSED;
        end
    end

    always_comb begin
        if (r_last != ST_HELD && cur_state == ST_HELD) begin
            poll_event = EV_HOLD_ENTER;
        end else if (r_last == ST_HELD && cur_state == ST_HELD) begin
            poll_event = EV_HOLDING;
        end else if (r_last == ST_HELD) begin
            poll_event = EV_HOLD_EXIT;
        end else if (cur_state == ST_OPEN && r_last == ST_CLOSED) begin
            poll_event = EV_RELEASE;
        end else begin
            poll_event = EV_NONE;
        end
    end

    always_comb begin
        n_hist   = r_hist;
        n_closed = r_closed;
        n_held   = r_held;
        n_count  = r_count;
        n_last   = r_last;
        unique case (i_item.op)
            OP_TICK: begin
                o_result.state      = tick_state;
                o_result.event_code = EV_NONE;
                if (i_fire) begin
                    n_hist   = hist_new;
                    n_closed = closed_new;
                    n_held   = held_new;
                    n_count  = count_new;
                end
            end
            OP_POLL: begin
                o_result.state      = cur_state;
                o_result.event_code = poll_event;
                if (i_fire) begin
                    n_last = cur_state;
                end
            end
            default: begin
                o_result.state      = cur_state;
                o_result.event_code = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= '1;
            r_closed <= 1'b0;
            r_held   <= 1'b0;
            r_count  <= '0;
            r_last   <= ST_OPEN;
        end else begin
            r_hist   <= n_hist;
            r_closed <= n_closed;
            r_held   <= n_held;
            r_count  <= n_count;
            r_last   <= n_last;
        end
    end

endmodule

// ===== rtl/core/switch_debounce_hold_events.sv =====
// Top level of the push-button debounce and long-press event block.
//
//   Channel  Direction  Handshake                 Payload
//   in       to block   i_in_valid / o_in_stall   i_operation, i_pin_low
//   out      from block o_out_valid / i_out_stall o_reported_state, o_press_event
//   cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One word is accepted every cycle while o_in_stall is low.
// The input register feeds the debounce logic, whose result is loaded into the output register.
// Reset is synchronous and active low; it restores the history to all ones and the state to open.
// A stall on the output holds the result and raises the input stall while a word waits in the input register.
module switch_debounce_hold_events #(
    parameter int HISTORY_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_operation,
    input  logic                             i_pin_low,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sdhe_pkg::ST_W-1:0]        o_reported_state,
    output logic [sdhe_pkg::EV_W-1:0]        o_press_event,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [sdhe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sdhe_pkg::*;

    logic [THR_W-1:0]  threshold;
    logic [HOLD_W-1:0] hold_ticks;

    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;

    logic out_load;
    logic s1_move;
    logic in_accept;

    assign out_load  = !r_out_valid || !i_out_stall;
    assign s1_move   = r_s1_valid && out_load;
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_accept = i_in_valid && !o_in_stall;

    sdhe_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (t_cfg_reg'(i_cfg_index)),
        .i_cfg_data   (i_cfg_data),
        .o_threshold  (threshold),
        .o_hold_ticks (hold_ticks)
    );

    sdhe_qual #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_qual (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_move),
        .i_item       (r_s1_item),
        .i_threshold  (threshold),
        .i_hold_ticks (hold_ticks),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= s1_move;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item.op      <= t_op'(i_operation);
            r_s1_item.pin_low <= i_pin_low;
        end
        if (s1_move) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_reported_state = r_out.state;
    assign o_press_event    = r_out.event_code;

`ifndef SYNTHESIS
    a_holding_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_code == EV_HOLDING || r_out.event_code == EV_HOLD_ENTER))
        |-> (r_out.state == ST_HELD))
        else $error("hold event reported without held state");

    a_release_means_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_code == EV_RELEASE) |-> (r_out.state == ST_OPEN))
        else $error("release event reported with switch not open");

    a_stalled_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("word in input register lost while output stalled");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the switch debounce and hold event block.
`timescale 1ns / 1ps

module tb;
    import sdhe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class press_scoreboard;
        logic [THR_W-1:0]  threshold;
        logic [HOLD_W-1:0] hold_limit;
        logic [7:0]        history;
        bit                closed;
        bit                held;
        int unsigned       hold_cnt;
        t_sw_state         cur_state;
        t_sw_state         polled_state;
        t_result           pending_results[$];
        int                mismatch_count;

        function new();
            threshold      = THRESHOLD_RESET;
            hold_limit     = HOLD_TICKS_RESET;
            history        = 8'hFF;
            closed         = 1'b0;
            held           = 1'b0;
            hold_cnt       = 0;
            cur_state      = ST_OPEN;
            polled_state   = ST_OPEN;
            mismatch_count = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_THRESHOLD) begin
                threshold = data[THR_W-1:0];
            end else begin
                hold_limit = data[HOLD_W-1:0];
            end
        endfunction

        function void predict_word(t_op op, logic pin);
            t_event    ev;
            t_sw_state prev;
            t_result   want;
            ev = EV_NONE;
            if (op == OP_TICK) begin
                history = {history[6:0], pin};
                if (history >= threshold) begin
                    closed = 1'b1;
                end else if (history == 8'h00) begin
                    closed = 1'b0;
                end
                if (cur_state == ST_CLOSED && hold_cnt < HOLD_COUNT_MAX) begin
                    hold_cnt++;
                end
                if (closed && hold_cnt >= hold_limit) begin
                    hold_cnt = hold_limit;
                    held = 1'b1;
                end else if (!closed) begin
                    hold_cnt = 0;
                    held = 1'b0;
                end
                if (!closed) begin
                    cur_state = ST_OPEN;
                end else if (held) begin
                    cur_state = ST_HELD;
                end else begin
                    cur_state = ST_CLOSED;
                end
            end else begin
                prev = polled_state;
                if (cur_state == ST_HELD) begin
                    ev = (prev == ST_HELD) ? EV_HOLDING : EV_HOLD_ENTER;
                end else if (prev == ST_HELD) begin
                    ev = EV_HOLD_EXIT;
                end else if (cur_state == ST_OPEN && prev == ST_CLOSED) begin
                    ev = EV_RELEASE;
                end
                polled_state = cur_state;
            end
            want.state = cur_state;
            want.event_code = ev;
            pending_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < 40) begin
                $display("[%0t] MISMATCH: %0s", $realtime, msg);
            end
            mismatch_count++;
        endtask

        task check_result(logic [ST_W-1:0] state_bits, logic [EV_W-1:0] ev_bits);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with none pending (state %0d event %0d)",
                                          state_bits, ev_bits));
            end else begin
                want = pending_results.pop_front();
                if (state_bits !== want.state) begin
                    report_mismatch($sformatf("reported_state %0d, expected %0d",
                                              state_bits, want.state));
                end
                if (ev_bits !== want.event_code) begin
                    report_mismatch($sformatf("press_event %0d, expected %0d",
                                              ev_bits, want.event_code));
                end
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation = 1'b0;
    logic                  i_pin_low = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ST_W-1:0]       o_reported_state;
    logic [EV_W-1:0]       o_press_event;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    press_scoreboard sb;
    int idle_pct = 26;
    int stall_pct = 26;
    bit hold_off_req = 1'b0;
    int cycle_count = 0;

    switch_debounce_hold_events uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_pin_low        (i_pin_low),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_reported_state (o_reported_state),
        .o_press_event    (o_press_event),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_result(o_reported_state, o_press_event);
        end
    end

    // A toggle of hold_off_req makes the receiver stall for a long stretch.
    initial begin
        int hold_left;
        bit seen_req;
        hold_left = 0;
        seen_req = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req != seen_req) begin
                seen_req = hold_off_req;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task send_word(t_op op, logic pin);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_pin_low <= pin;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.predict_word(op, pin);
    endtask

    task send_ticks(logic pin, int n);
        repeat (n) send_word(OP_TICK, pin);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task write_config(logic [CFG_DATA_W-1:0] thr_data, logic [CFG_DATA_W-1:0] hold_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_THRESHOLD;
        i_cfg_data <= thr_data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_register(REG_THRESHOLD, thr_data);
        i_cfg_index <= REG_HOLD_TICKS;
        i_cfg_data <= hold_data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_register(REG_HOLD_TICKS, hold_data);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int count;
        int len;
        int r;
        logic level;
        logic [THR_W-1:0] thr;
        logic [HOLD_W-1:0] hold;

        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the all-ones history closes the switch on the first tick.
        send_word(OP_POLL, 1'b0);
        send_word(OP_TICK, 1'b0);
        send_word(OP_POLL, 1'b1);
        send_ticks(1'b0, 7);
        send_word(OP_POLL, 1'b0);

        // A zero hold limit makes the first closed tick report held.
        wait_drained();
        write_config(10'h000, 10'd0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_POLL, 1'b0);
        send_word(OP_POLL, 1'b0);

        // Raising the hold limit keeps a held switch held until it opens.
        wait_drained();
        write_config(10'h3FF, 10'h3FF);
        send_word(OP_TICK, 1'b1);
        send_word(OP_POLL, 1'b0);
        send_ticks(1'b0, 8);
        send_word(OP_POLL, 1'b0);

        // Lowering the limit below the count saturates on the next closed tick.
        wait_drained();
        write_config(10'h000, 10'h3FF);
        send_ticks(1'b1, 4);
        wait_drained();
        write_config(10'h000, 10'd2);
        send_word(OP_TICK, 1'b1);
        send_word(OP_POLL, 1'b0);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            thr = (p == 1) ? 8'h00 : (p == 4) ? 8'hFF : 8'($urandom_range(254, 1));
            hold = (p == 2) ? 10'd0 : (p == 6) ? 10'h3FF : 10'($urandom_range(12, 1));
            write_config({2'($urandom_range(3)), thr}, hold);
            idle_pct = (p == 5) ? 0 : 26;
            stall_pct = (p == 5) ? 0 : 26;
            if (p == 3) begin
                hold_off_req <= ~hold_off_req;
            end
            count = 0;
            while (count < 75) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    level = 1'($urandom_range(1));
                    len = $urandom_range(16, 1);
                    repeat (len) begin
                        send_word(OP_TICK, level);
                        count++;
                        if ($urandom_range(99) < 20) begin
                            send_word(OP_POLL, 1'($urandom_range(1)));
                            count++;
                        end
                    end
                end else if (r < 85) begin
                    send_word(OP_POLL, 1'($urandom_range(1)));
                    count++;
                end else begin
                    send_word(OP_TICK, 1'($urandom_range(1)));
                    count++;
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
